[hdl/servo_pulse_normalizer_defines.svh]
// Assertion macros shared by the servo pulse normalizer checkers.
// Needs signals clk and rst in the scope where a macro is used.
`ifndef SERVO_PULSE_NORMALIZER_DEFINES_SVH
`define SERVO_PULSE_NORMALIZER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SPN_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spn check failed");

// next-cycle implication, disabled in reset
`define SPN_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spn check failed");

`endif

[hdl/spn_pkg.sv]
// Package for the servo pulse normalizer: constants, register indexes and
// the microcode ROM of the channel sequencer. No dependencies.
package spn_pkg;

  localparam int PULSE_BITS_DEF = 16;
  localparam int RAW_BITS       = 16;
  localparam int PCT_BITS       = 8;
  localparam int ABS_BITS       = 7;
  localparam int Q_BITS         = 7;
  localparam int DELTA_BITS     = 10;
  localparam int TIMER_BITS     = 16;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int IN_DATA_BITS   = 48;
  localparam int OUT_DATA_BITS  = 48;
  localparam int USER_BITS      = 2;

  localparam int PULSE_MIN  = 600;
  localparam int PULSE_MAX  = 2500;
  localparam int CLAMP_LOW  = 800;
  localparam int CLAMP_HIGH = 2300;
  localparam int PCT_SCALE  = 101;
  localparam int PCT_LIMIT  = 100;

  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DELTA       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STARTUP     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_REV_STEER   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_REV_THROT   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_REV_AUX     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_AUX_LOCAL   = 3'd6;

  localparam logic [1:0] CH_STEER = 2'd0;
  localparam logic [1:0] CH_AUX   = 2'd2;

  localparam int STEP_BITS = 3;
  typedef logic [STEP_BITS-1:0] step_t;

  typedef enum logic [2:0] {
    OP_ACCEPT, OP_FRONT, OP_LOAD, OP_SETUP, OP_DIV, OP_STORE, OP_NEXT, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER, COND_NO_INPUT, COND_NOT_RUN, COND_CH_LOCAL,
    COND_ZERO_PCT, COND_DIV_MORE, COND_MORE_CH, COND_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  localparam step_t S_ACCEPT = 3'd0;
  localparam step_t S_FRONT  = 3'd1;
  localparam step_t S_LOAD   = 3'd2;
  localparam step_t S_SETUP  = 3'd3;
  localparam step_t S_DIV    = 3'd4;
  localparam step_t S_STORE  = 3'd5;
  localparam step_t S_NEXT   = 3'd6;
  localparam step_t S_EMIT   = 3'd7;

  // the step after S_EMIT wraps to S_ACCEPT
  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    case (s)
      S_ACCEPT: w = '{OP_ACCEPT, COND_NO_INPUT, S_ACCEPT};
      S_FRONT:  w = '{OP_FRONT,  COND_NOT_RUN,  S_EMIT};
      S_LOAD:   w = '{OP_LOAD,   COND_CH_LOCAL, S_NEXT};
      S_SETUP:  w = '{OP_SETUP,  COND_ZERO_PCT, S_NEXT};
      S_DIV:    w = '{OP_DIV,    COND_DIV_MORE, S_DIV};
      S_STORE:  w = '{OP_STORE,  COND_NEVER,    S_NEXT};
      S_NEXT:   w = '{OP_NEXT,   COND_MORE_CH,  S_LOAD};
      S_EMIT:   w = '{OP_EMIT,   COND_OUT_FULL, S_EMIT};
      default:  w = '{OP_ACCEPT, COND_NEVER,    S_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

[hdl/servo_pulse_normalizer.sv]
// Servo pulse normalizer: microcoded sequencer over a shared divider.
// Depends on spn_pkg.
//
// Input stream s_axis: one word per item, raw pulse widths in tdata, the
// tick and new-frame flags in tuser. Output stream m_axis: one word per
// item with the three held percentages, their magnitudes, and in tuser the
// fresh-data and initializing flags. cfg_*: register writes, always ready;
// write only while the block is idle.
// Each item runs through an eight-step microcode program. An item without a
// running frame steps through accept, front and emit. A running frame visits
// each channel: load, setup, 7 divide steps (one quotient bit each through the
// shared restoring divider), store, next; setup jumps straight to next when the
// percentage is zero, and a local aux channel goes from load straight to next.
// The result sits in an output register; the sequencer then goes back to
// accept the next item while the receiver stalls, and waits at its emit
// step only if the previous result is still not taken.
// Reset (rst, synchronous) restores register defaults, clears the captured
// endpoints and percentages and empties the output register.
module servo_pulse_normalizer #(
  parameter int PULSE_BITS = spn_pkg::PULSE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // raw_steering, raw_throttle, raw_aux
  input  logic [spn_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // tick, new_frame
  input  logic [spn_pkg::USER_BITS-1:0]      s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // steering_pct, steering_abs, throttle_pct, throttle_abs, aux_pct, aux_abs
  output logic [spn_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  // data_fresh, initializing
  output logic [spn_pkg::USER_BITS-1:0]      m_axis_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spn_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [spn_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import spn_pkg::*;

  localparam int PW = PULSE_BITS + 2;
  localparam int DW = PULSE_BITS + 1;
  localparam int RW = PULSE_BITS + 8;
  localparam int KW = $clog2(Q_BITS);

  typedef enum logic [2:0] {
    PH_FIRST = 3'b001,
    PH_WAIT  = 3'b010,
    PH_RUN   = 3'b100
  } phase_t;

  logic                    enable;
  logic [DELTA_BITS-1:0]   endpoint_delta;
  logic [TIMER_BITS-1:0]   startup_ticks;
  logic [2:0]              reverse;
  logic                    aux_is_local;

  step_t                   step, step_next;
  uword_t                  uw;
  logic                    jump;

  phase_t                  phase;
  logic [TIMER_BITS-1:0]   timer, timer_dec;
  logic                    init_flag;
  logic                    fresh;
  logic                    in_tick, in_frame;
  logic [PULSE_BITS-1:0]   in_raw [3];

  logic signed [PW-1:0]    centre [3];
  logic signed [PW-1:0]    left   [3];
  logic signed [PW-1:0]    right  [3];
  logic signed [PCT_BITS-1:0] pct [3];

  logic [1:0]              ch;
  logic [PULSE_BITS-1:0]   x;
  logic                    oor;
  logic                    below;
  logic [RW-1:0]           rem;
  logic [DW-1:0]           dvs;
  logic [Q_BITS-1:0]       q;
  logic [KW-1:0]           k;

  logic [PULSE_BITS-1:0]   raw_sel;
  logic signed [PW-1:0]    xs, cc, lnew, rnew;
  logic [DW-1:0]           mag, div_sel;
  logic [RW:0]             trial;
  logic [ABS_BITS-1:0]     mag_lim;
  logic                    neg;
  logic [ABS_BITS-1:0]     abs_v [3];
  logic signed [PCT_BITS-1:0] neg_pct [3];

  assign cfg_ready     = 1'b1;
  assign uw            = ucode_rom(step);
  assign s_axis_tready = (uw.op == OP_ACCEPT);

  assign raw_sel   = in_raw[ch];
  assign xs        = $signed({2'b00, x});
  assign cc        = centre[ch];
  assign lnew      = (xs < left[ch])  ? xs : left[ch];
  assign rnew      = (xs > right[ch]) ? xs : right[ch];
  assign mag       = (xs < cc) ? DW'(cc - xs) : DW'(xs - cc);
  assign div_sel   = (xs < cc) ? DW'(cc - lnew) : DW'(rnew - cc);
  assign trial     = {1'b0, rem} - {1'b0, (RW'(dvs) << k)};
  assign mag_lim   = (q > Q_BITS'(PCT_LIMIT)) ? ABS_BITS'(PCT_LIMIT) : q;
  assign neg       = below ^ reverse[ch];
  assign timer_dec = (in_tick && timer != '0) ? timer - 1'b1 : timer;

  always_comb begin
    case (uw.cond)
      COND_NEVER:    jump = 1'b0;
      COND_NO_INPUT: jump = !s_axis_tvalid;
      COND_NOT_RUN:  jump = !(enable && in_frame && phase == PH_RUN);
      COND_CH_LOCAL: jump = (ch == CH_AUX) && aux_is_local;
      COND_ZERO_PCT: jump = oor || (xs == cc);
      COND_DIV_MORE: jump = (k != '0);
      COND_MORE_CH:  jump = (ch != CH_AUX);
      COND_OUT_FULL: jump = m_axis_tvalid && !m_axis_tready;
      default:       jump = 1'b0;
    endcase
    step_next = jump ? uw.target : step + 1'b1;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_pct[i] = -pct[i];
      abs_v[i]   = pct[i][PCT_BITS-1] ? neg_pct[i][ABS_BITS-1:0] : pct[i][ABS_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b1;
      endpoint_delta <= DELTA_BITS'(200);
      startup_ticks  <= TIMER_BITS'(100);
      reverse        <= '0;
      aux_is_local   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE:    enable         <= cfg_data[0];
        REG_DELTA:     endpoint_delta <= cfg_data[DELTA_BITS-1:0];
        REG_STARTUP:   startup_ticks  <= cfg_data[TIMER_BITS-1:0];
        REG_REV_STEER: reverse[0]     <= cfg_data[0];
        REG_REV_THROT: reverse[1]     <= cfg_data[0];
        REG_REV_AUX:   reverse[2]     <= cfg_data[0];
        REG_AUX_LOCAL: aux_is_local   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= S_ACCEPT;
      phase         <= PH_FIRST;
      timer         <= '0;
      init_flag     <= 1'b1;
      fresh         <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        centre[i] <= '0;
        left[i]   <= '0;
        right[i]  <= '0;
        pct[i]    <= '0;
      end
    end else begin
      step <= step_next;
      if (m_axis_tvalid && m_axis_tready && uw.op != OP_EMIT) m_axis_tvalid <= 1'b0;
      case (uw.op)
        OP_ACCEPT: begin
          if (s_axis_tvalid) begin
            in_tick   <= s_axis_tuser[0];
            in_frame  <= s_axis_tuser[1];
            in_raw[0] <= s_axis_tdata[PULSE_BITS-1:0];
            in_raw[1] <= s_axis_tdata[RAW_BITS +: PULSE_BITS];
            in_raw[2] <= s_axis_tdata[2*RAW_BITS +: PULSE_BITS];
            fresh     <= 1'b0;
          end
        end
        OP_FRONT: begin
          ch <= CH_STEER;
          if (enable) begin
            timer <= (in_frame && phase == PH_FIRST) ? startup_ticks : timer_dec;
            if (in_frame) begin
              case (phase)
                PH_FIRST: phase <= PH_WAIT;
                PH_WAIT: begin
                  fresh <= 1'b1;
                  if (timer_dec == '0) begin
                    for (int i = 0; i < 3; i++) begin
                      if (i != 2 || !aux_is_local) begin
                        centre[i] <= $signed({2'b00, in_raw[i]});
                        left[i]   <= $signed({2'b00, in_raw[i]}) - $signed(PW'(endpoint_delta));
                        right[i]  <= $signed({2'b00, in_raw[i]}) + $signed(PW'(endpoint_delta));
                      end
                    end
                    phase     <= PH_RUN;
                    init_flag <= 1'b0;
                  end
                end
                PH_RUN:  fresh <= 1'b1;
                default: phase <= PH_FIRST;
              endcase
            end
          end
        end
        OP_LOAD: begin
          oor <= (raw_sel < PULSE_BITS'(PULSE_MIN)) || (raw_sel > PULSE_BITS'(PULSE_MAX));
          if (raw_sel < PULSE_BITS'(CLAMP_LOW))       x <= PULSE_BITS'(CLAMP_LOW);
          else if (raw_sel > PULSE_BITS'(CLAMP_HIGH)) x <= PULSE_BITS'(CLAMP_HIGH);
          else                                        x <= raw_sel;
        end
        OP_SETUP: begin
          if (oor || xs == cc) begin
            pct[ch] <= '0;
          end else begin
            below <= (xs < cc);
            if (xs < cc) left[ch]  <= lnew;
            else         right[ch] <= rnew;
            rem <= RW'(mag) * RW'(PCT_SCALE);
            dvs <= div_sel;
            q   <= '0;
            k   <= KW'(Q_BITS - 1);
          end
        end
        OP_DIV: begin
          if (!trial[RW]) begin
            rem  <= trial[RW-1:0];
            q[k] <= 1'b1;
          end
          k <= k - 1'b1;
        end
        OP_STORE: begin
          pct[ch] <= neg ? -$signed({1'b0, mag_lim}) : $signed({1'b0, mag_lim});
        end
        OP_NEXT: ch <= ch + 1'b1;
        OP_EMIT: begin
          if (!(m_axis_tvalid && !m_axis_tready)) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {3'b000, abs_v[2], pct[2], abs_v[1], pct[1], abs_v[0], pct[0]};
            m_axis_tuser  <= {init_flag, fresh};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[hdl/spn_checker.sv]
// Port-level checker for the servo pulse normalizer, bound to the top level.
// Depends on spn_pkg and servo_pulse_normalizer_defines.svh.
`include "servo_pulse_normalizer_defines.svh"

module spn_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [spn_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  input logic [spn_pkg::USER_BITS-1:0]      m_axis_tuser
);
  import spn_pkg::*;

  localparam logic signed [PCT_BITS-1:0] PCT_LIM = PCT_BITS'(PCT_LIMIT);

  logic signed [PCT_BITS-1:0] p [3];
  logic signed [PCT_BITS-1:0] pn [3];
  logic [ABS_BITS-1:0]        a [3];
  logic                       pct_ok, abs_ok;
  logic                       init_done;

  always_comb begin
    pct_ok = 1'b1;
    abs_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      p[i]  = m_axis_tdata[i*(PCT_BITS+ABS_BITS) +: PCT_BITS];
      a[i]  = m_axis_tdata[i*(PCT_BITS+ABS_BITS)+PCT_BITS +: ABS_BITS];
      pn[i] = -p[i];
      if (p[i] > PCT_LIM || p[i] < -PCT_LIM) pct_ok = 1'b0;
      if (a[i] != (p[i][PCT_BITS-1] ? pn[i][ABS_BITS-1:0] : p[i][ABS_BITS-1:0]))
        abs_ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_done <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && !m_axis_tuser[1]) begin
      init_done <= 1'b1;
    end
  end

  `SPN_ASSERT_NOW(a_pct_range, m_axis_tvalid, pct_ok)
  `SPN_ASSERT_NOW(a_abs_match, m_axis_tvalid, abs_ok)
  `SPN_ASSERT_NOW(a_init_sticky, m_axis_tvalid && init_done, !m_axis_tuser[1])
  `SPN_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind servo_pulse_normalizer spn_checker u_spn_checker (.*);
